// File: rtl/core/lrs_pkg.sv
// shared types, constants and sigmoid table builder for the logistic regression scorer
`default_nettype none

package lrs_pkg;

    // fixed field widths
    localparam int FRAC_BITS = 16;
    localparam int VALUE_W   = 32;
    localparam int MSEL_W    = 2;
    localparam int TIDX_W    = 5;
    localparam int LOGIT_W   = FRAC_BITS + 5;
    localparam int PROB_W    = 16;
    localparam int ACC_W     = 64;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_MSEL_LO = 0;
    localparam int S_TIDX_LO = S_MSEL_LO + MSEL_W;
    localparam int S_TVAL_LO = S_TIDX_LO + TIDX_W;
    localparam int S_USED_W  = S_TVAL_LO + VALUE_W;
    localparam int M_USED_W  = LOGIT_W + PROB_W;

    // tuser code: what an input transaction carries
    localparam logic CMD_COEF = 1'b0;
    localparam logic CMD_TERM = 1'b1;

    // sigmoid table geometry
    localparam int SIG_DEPTH = 256;
    localparam int SIG_IDX_W = $clog2(SIG_DEPTH + 1);
    localparam int FRAC_SH   = FRAC_BITS + 4;
    localparam int POS_W     = LOGIT_W + SIG_IDX_W;
    localparam int SIDX_W    = POS_W - FRAC_SH;
    localparam int IP_W      = PROB_W + FRAC_SH;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] SIG_H_RAW = (64'd1 << 34) / SIG_DEPTH;
    localparam logic [63:0] SIG_H     = (SIG_H_RAW > ONE_Q30) ? ONE_Q30 : SIG_H_RAW;

    typedef logic [SIG_DEPTH:0][PROB_W-1:0] sig_points_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ICPT,
        ST_LOGIT,
        ST_SIG,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_en;
        logic acc_en;
        logic icpt_en;
        logic logit_en;
        logic sig_en;
        logic out_load;
    } lrs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_term;
        logic last;
        logic out_free;
    } lrs_status_t;

    // shift-subtract quotient, evaluated only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid(16k/D) for k = 0..D, in Q0.16
    function automatic sig_points_t build_sig_points();
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] p;
        sig_points_t pts;
        term = ONE_Q30;
        r    = ONE_Q30;
        e    = ONE_Q30;
        pts  = '0;
        // e^(-16/D) from a truncated taylor series
        for (int n = 1; n <= 16; n++) begin
            term = udiv64((term * SIG_H) >> 30, 64'(n));
            if (n % 2 == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int k = 0; k <= SIG_DEPTH; k++) begin
            if (k > 0) begin
                e = (e * r + (ONE_Q30 >> 1)) >> 30;
            end
            den = ONE_Q30 + e;
            p   = udiv64((64'd1 << 46) + (den >> 1), den);
            if (p > 64'd65535) begin
                p = 64'd65535;
            end
            pts[k] = p[PROB_W-1:0];
        end
        return pts;
    endfunction

    localparam sig_points_t SIG_POINTS = build_sig_points();

endpackage

`default_nettype wire

// File: rtl/core/lrs_ctrl.sv
// sequencing state machine for the logistic regression scorer
`default_nettype none

module lrs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire lrs_pkg::lrs_status_t status,
    output lrs_pkg::lrs_cmd_t        cmd
);

    lrs_pkg::state_t state_reg;
    lrs_pkg::state_t state_next;
    logic            accept;

    assign accept = s_tvalid && s_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrs_pkg::ST_IDLE: begin
                if (accept && status.in_term == lrs_pkg::CMD_TERM) begin
                    state_next = lrs_pkg::ST_MUL;
                end
            end
            lrs_pkg::ST_MUL: begin
                state_next = lrs_pkg::ST_ACC;
            end
            lrs_pkg::ST_ACC: begin
                priority if (status.last) begin
                    state_next = lrs_pkg::ST_ICPT;
                end else if (accept && status.in_term == lrs_pkg::CMD_TERM) begin
                    state_next = lrs_pkg::ST_MUL;
                end else begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            lrs_pkg::ST_ICPT: begin
                state_next = lrs_pkg::ST_LOGIT;
            end
            lrs_pkg::ST_LOGIT: begin
                state_next = lrs_pkg::ST_SIG;
            end
            lrs_pkg::ST_SIG: begin
                state_next = lrs_pkg::ST_OUT;
            end
            lrs_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs per state
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            lrs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lrs_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
            end
            lrs_pkg::ST_ACC: begin
                cmd.acc_en = 1'b1;
                s_tready   = !status.last;
            end
            lrs_pkg::ST_ICPT: begin
                cmd.icpt_en = 1'b1;
            end
            lrs_pkg::ST_LOGIT: begin
                cmd.logit_en = 1'b1;
            end
            lrs_pkg::ST_SIG: begin
                cmd.sig_en = 1'b1;
            end
            lrs_pkg::ST_OUT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.accept = s_tvalid && s_tready;
    end

endmodule

`default_nettype wire

// File: rtl/core/lrs_datapath.sv
// coefficient memory, multiply-accumulate, logit clamp and sigmoid interpolation
`default_nettype none

module lrs_datapath #(
    parameter int NUM_MODELS = 3,
    parameter int NUM_TERMS  = 19
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [lrs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [lrs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire lrs_pkg::lrs_cmd_t               cmd,
    output lrs_pkg::lrs_status_t                 status
);

    localparam int SLOTS   = NUM_TERMS + 1;
    localparam int ENTRIES = NUM_MODELS * SLOTS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS);

    localparam logic signed [lrs_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(lrs_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [lrs_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(lrs_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [lrs_pkg::ACC_W-1:0] LIM =
        lrs_pkg::ACC_W'(64'sd16 <<< lrs_pkg::FRAC_BITS);

    // saturating signed add
    function automatic logic signed [lrs_pkg::ACC_W-1:0] sat_add(
        input logic signed [lrs_pkg::ACC_W-1:0] a,
        input logic signed [lrs_pkg::ACC_W-1:0] b
    );
        logic signed [lrs_pkg::ACC_W-1:0] s;
        s = a + b;
        if (a[lrs_pkg::ACC_W-1] == b[lrs_pkg::ACC_W-1] &&
            s[lrs_pkg::ACC_W-1] != a[lrs_pkg::ACC_W-1]) begin
            s = a[lrs_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    // input field unpacking
    logic        [lrs_pkg::MSEL_W-1:0]  in_msel;
    logic        [lrs_pkg::TIDX_W-1:0]  in_tidx;
    logic signed [lrs_pkg::VALUE_W-1:0] in_value;
    logic                               in_model_ok;
    logic        [ADDR_W-1:0]           base_addr;
    logic        [ADDR_W-1:0]           wr_addr;
    logic        [ADDR_W-1:0]           rd_addr;
    logic                               wr_en;

    assign in_msel     = s_tdata[lrs_pkg::S_MSEL_LO +: lrs_pkg::MSEL_W];
    assign in_tidx     = s_tdata[lrs_pkg::S_TIDX_LO +: lrs_pkg::TIDX_W];
    assign in_value    = s_tdata[lrs_pkg::S_TVAL_LO +: lrs_pkg::VALUE_W];
    assign in_model_ok = int'(in_msel) < NUM_MODELS;
    assign base_addr   = ADDR_W'(in_msel) * SLOTS_A;
    assign wr_addr     = base_addr + ADDR_W'(in_tidx);
    assign rd_addr     = wr_addr + ADDR_W'(1);
    assign wr_en       = cmd.accept && s_tuser == lrs_pkg::CMD_COEF && in_model_ok &&
                         int'(in_tidx) < SLOTS;

    // coefficient memory, term and intercept read on a predictor transaction
    logic signed [lrs_pkg::VALUE_W-1:0] coef_mem [ENTRIES];
    logic signed [lrs_pkg::VALUE_W-1:0] coef_rd_reg;
    logic signed [lrs_pkg::VALUE_W-1:0] icpt_rd_reg;
    logic                               term_capture;

    assign term_capture = cmd.accept && s_tuser == lrs_pkg::CMD_TERM;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            coef_mem[wr_addr] <= in_value;
        end
        if (term_capture) begin
            coef_rd_reg <= coef_mem[rd_addr];
            icpt_rd_reg <= coef_mem[base_addr];
        end
    end

    // captured predictor
    logic signed [lrs_pkg::VALUE_W-1:0] val_reg;
    logic                               term_ok_reg;
    logic                               model_ok_reg;
    logic                               last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
        end else if (term_capture) begin
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (term_capture) begin
            val_reg      <= in_value;
            model_ok_reg <= in_model_ok;
            term_ok_reg  <= in_model_ok && int'(in_tidx) < NUM_TERMS;
        end
    end

    // product of coefficient and predictor
    logic signed [lrs_pkg::ACC_W-1:0] prod_reg;
    logic signed [lrs_pkg::ACC_W-1:0] prod_next;

    assign prod_next = term_ok_reg ? lrs_pkg::ACC_W'(coef_rd_reg) * lrs_pkg::ACC_W'(val_reg)
                                   : '0;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // accumulator and intercept sum
    logic signed [lrs_pkg::ACC_W-1:0] acc_reg;
    logic signed [lrs_pkg::ACC_W-1:0] acc_next;
    logic signed [lrs_pkg::ACC_W-1:0] icpt_q32;
    logic signed [lrs_pkg::ACC_W-1:0] sum_reg;

    assign icpt_q32 = model_ok_reg ? (lrs_pkg::ACC_W'(icpt_rd_reg) <<< lrs_pkg::FRAC_BITS) : '0;

    always_comb begin
        acc_next = acc_reg;
        priority if (cmd.acc_en) begin
            acc_next = sat_add(acc_reg, prod_reg);
        end else if (cmd.icpt_en) begin
            acc_next = '0;
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.icpt_en) begin
            sum_reg <= sat_add(acc_reg, icpt_q32);
        end
    end

    // floor to q16.16 and clamp
    logic signed [lrs_pkg::ACC_W-1:0]   sum_sh;
    logic signed [lrs_pkg::ACC_W-1:0]   clamped;
    logic signed [lrs_pkg::LOGIT_W-1:0] logit_reg;

    assign sum_sh = sum_reg >>> lrs_pkg::FRAC_BITS;

    always_comb begin
        priority if (sum_sh < -LIM) begin
            clamped = -LIM;
        end else if (sum_sh > LIM - 1) begin
            clamped = LIM - 1;
        end else begin
            clamped = sum_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.logit_en) begin
            logit_reg <= lrs_pkg::LOGIT_W'(clamped);
        end
    end

    // table lookup on |logit|
    logic                               neg;
    logic [lrs_pkg::LOGIT_W-1:0]        mag;
    logic [lrs_pkg::POS_W-1:0]          pos;
    logic [lrs_pkg::SIDX_W-1:0]         sidx;
    logic [lrs_pkg::SIG_IDX_W-1:0]      tidx;
    logic [lrs_pkg::PROB_W-1:0]         p0;
    logic [lrs_pkg::PROB_W-1:0]         p1;
    logic [lrs_pkg::PROB_W-1:0]         p0_next;
    logic [lrs_pkg::PROB_W-1:0]         d_next;
    logic [lrs_pkg::PROB_W-1:0]         p0_reg;
    logic [lrs_pkg::PROB_W-1:0]         d_reg;
    logic [lrs_pkg::FRAC_SH-1:0]        frac_reg;
    logic                               neg_reg;
    logic signed [lrs_pkg::LOGIT_W-1:0] logit_hold_reg;

    assign neg  = logit_reg[lrs_pkg::LOGIT_W-1];
    assign mag  = neg ? (~logit_reg + lrs_pkg::LOGIT_W'(1)) : logit_reg;
    assign pos  = lrs_pkg::POS_W'(mag) * lrs_pkg::POS_W'(lrs_pkg::SIG_DEPTH);
    assign sidx = pos[lrs_pkg::POS_W-1:lrs_pkg::FRAC_SH];
    assign tidx = sidx[lrs_pkg::SIG_IDX_W-1:0];
    assign p0   = lrs_pkg::SIG_POINTS[tidx];
    assign p1   = lrs_pkg::SIG_POINTS[tidx + lrs_pkg::SIG_IDX_W'(1)];

    always_comb begin
        if (int'(sidx) >= lrs_pkg::SIG_DEPTH) begin
            p0_next = lrs_pkg::SIG_POINTS[lrs_pkg::SIG_DEPTH];
            d_next  = '0;
        end else begin
            p0_next = p0;
            d_next  = (p1 > p0) ? p1 - p0 : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sig_en) begin
            p0_reg         <= p0_next;
            d_reg          <= d_next;
            frac_reg       <= pos[lrs_pkg::FRAC_SH-1:0];
            neg_reg        <= neg;
            logit_hold_reg <= logit_reg;
        end
    end

    // interpolation, mirror for negative logits, saturation
    logic [lrs_pkg::IP_W-1:0]     interp;
    logic [lrs_pkg::PROB_W:0]     p_sum;
    logic [lrs_pkg::PROB_W:0]     p_mir;
    logic [lrs_pkg::PROB_W-1:0]   prob;

    assign interp = lrs_pkg::IP_W'(d_reg) * lrs_pkg::IP_W'(frac_reg);
    assign p_sum  = (lrs_pkg::PROB_W+1)'(p0_reg) +
                    (lrs_pkg::PROB_W+1)'(interp[lrs_pkg::IP_W-1:lrs_pkg::FRAC_SH]);
    assign p_mir  = neg_reg ? ((lrs_pkg::PROB_W+1)'(1) << lrs_pkg::PROB_W) - p_sum : p_sum;
    assign prob   = p_mir[lrs_pkg::PROB_W] ? '1 : p_mir[lrs_pkg::PROB_W-1:0];

    // output register
    logic                               m_tvalid_reg;
    logic signed [lrs_pkg::LOGIT_W-1:0] logit_out_reg;
    logic        [lrs_pkg::PROB_W-1:0]  prob_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            logit_out_reg <= logit_hold_reg;
            prob_out_reg  <= prob;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(lrs_pkg::M_TDATA_W - lrs_pkg::M_USED_W){1'b0}},
                       prob_out_reg, logit_out_reg};

    // status back to the controller
    assign status.in_term  = s_tuser;
    assign status.last     = last_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

// File: rtl/core/logistic_regression_scorer_top.sv
// top level of the logistic regression scorer
`default_nettype none

// Scores records with one of NUM_MODELS logistic regression coefficient sets.
// A tuser=0 transaction writes a coefficient (slot 0 is the intercept); a
// tuser=1 transaction multiplies its Q16.16 predictor by the stored
// coefficient and adds it into a saturating 64-bit accumulator. After a
// predictor is accepted, the 32x32 multiply on the coefficient read at
// acceptance runs in the multiply state and the saturating accumulate in the
// accumulate state, which takes the next predictor unless tlast was set. The
// result of the predictor with tlast set is offered after multiply,
// accumulate, intercept add, floor and clamp to +/-16, sigmoid table lookup
// and interpolation into the output register, and is held back while an
// earlier result still waits for m_tready in the output register; s_tready is
// low meanwhile and rises again as the result is offered. The result carries
// the clamped logit and a Q0.16 probability. Coefficients must be written
// before they are used; there is no clearing pass after reset.
module logistic_regression_scorer_top #(
    parameter int NUM_MODELS = 3,
    parameter int NUM_TERMS  = 19
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // model_select[1:0], term_index[6:2], term_value[38:7], zero pad [39]
    input  wire logic [lrs_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd: 0 coefficient write, 1 predictor term
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // logit[20:0], probability[36:21], zero pad [39:37]
    output logic      [lrs_pkg::M_TDATA_W-1:0] m_tdata
);

    lrs_pkg::lrs_cmd_t    cmd;
    lrs_pkg::lrs_status_t status;

    // sequencing
    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    lrs_datapath #(
        .NUM_MODELS (NUM_MODELS),
        .NUM_TERMS  (NUM_TERMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire
